[rtl/vertex_split_by_tangent_top_assert.svh]
// Assertion macros shared by the checker of the vertex split block
`ifndef VERTEX_SPLIT_BY_TANGENT_TOP_ASSERT_SVH
`define VERTEX_SPLIT_BY_TANGENT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define VSBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define VSBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vsbt_pkg.sv]
// Types, constants and compare functions of the vertex split block
package vsbt_pkg;

  localparam int MAX_VERTS    = 4096;
  localparam int MAX_VARIANTS = 8192;
  localparam int VERT_W       = $clog2(MAX_VERTS);
  localparam int SLOT_W       = $clog2(MAX_VARIANTS);
  localparam int USED_W       = $clog2(MAX_VARIANTS + 1);
  localparam int IDX_W        = 14;
  localparam int VC_W         = 13;
  localparam int WORD_W       = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_VERT_TOTAL = 3'd0;
  localparam logic [VC_W-1:0]       VC_RESET        = 13'd4096;

  // result status codes
  typedef enum logic [2:0] {
    ST_REUSED     = 3'd0,
    ST_NEW_SRC    = 3'd1,
    ST_NEW_APPEND = 3'd2,
    ST_FULL       = 3'd3,
    ST_RANGE      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_WALK
  } fsm_t;

  // list head entry
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } head_t;

  typedef struct packed {
    logic              rd_en;
    logic [VERT_W-1:0] rd_addr;
    logic              wr_en;
    logic [VERT_W-1:0] wr_addr;
    head_t             wr_data;
  } head_req_t;

  // variant store entry
  typedef struct packed {
    logic [2*WORD_W-1:0] frame_xy;
    logic [2*WORD_W-1:0] frame_zw;
    logic [IDX_W-1:0]    target;
    logic                link_ok;
    logic [SLOT_W-1:0]   link;
  } variant_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    variant_t          wr_data;
  } var_req_t;

  // single-precision equality: +0 == -0, NaN equals nothing
  function automatic logic float_eq(input logic [WORD_W-1:0] a,
                                    input logic [WORD_W-1:0] b);
    logic nan_a;
    logic nan_b;
    logic [WORD_W-1:0] both;
    nan_a = a[WORD_W-2:0] > 31'h7F80_0000;
    nan_b = b[WORD_W-2:0] > 31'h7F80_0000;
    both  = a | b;
    return !nan_a && !nan_b && ((a == b) || (both[WORD_W-2:0] == '0));
  endfunction

  function automatic logic frame_eq(input variant_t e,
                                    input logic [WORD_W-1:0] x,
                                    input logic [WORD_W-1:0] y,
                                    input logic [WORD_W-1:0] z,
                                    input logic [WORD_W-1:0] w);
    return float_eq(e.frame_xy[WORD_W-1:0], x) &&
           float_eq(e.frame_xy[2*WORD_W-1:WORD_W], y) &&
           float_eq(e.frame_zw[WORD_W-1:0], z) &&
           float_eq(e.frame_zw[2*WORD_W-1:WORD_W], w);
  endfunction

endpackage

[rtl/vertex_split_by_tangent_top.sv]
// Steps: an out-of-range corner is answered from idle; otherwise the head is read, the list
//   is walked entry by entry to a hit, and a miss allocates a variant. done pulses with the result.
// Throughput: one corner at a time; busy drops as done rises, so a new word can be
//   taken in the result cycle. The list walk, one variant read a cycle, sets the rate.
// Reset: synchronous; then a pass clears every head memory entry, busy high.
module vertex_split_by_tangent_top (
  input  logic                                clk,
  input  logic                                rst,
  // corner input
  input  logic                                start,
  output logic                                busy,
  input  logic [vsbt_pkg::VERT_W-1:0]         src_vert,
  input  logic [vsbt_pkg::WORD_W-1:0]         tangent_x,
  input  logic [vsbt_pkg::WORD_W-1:0]         tangent_y,
  input  logic [vsbt_pkg::WORD_W-1:0]         tangent_z,
  input  logic [vsbt_pkg::WORD_W-1:0]         handed_sign,
  // result
  output logic                                done,
  output logic [vsbt_pkg::IDX_W-1:0]          dst_vert,
  output logic [2:0]                          status,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vsbt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [vsbt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [vsbt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  vsbt_pkg::fsm_t   state, state_next;
  logic [vsbt_pkg::VERT_W-1:0] clr_addr;
  logic [vsbt_pkg::VC_W-1:0]   vert_total;
  logic [vsbt_pkg::USED_W-1:0] variants_used, variants_used_next;
  logic [vsbt_pkg::IDX_W-1:0]  appended_count, appended_count_next;

  // latched corner
  logic [vsbt_pkg::VERT_W-1:0] sv;
  logic [vsbt_pkg::WORD_W-1:0] tx, ty, tz, tw;
  vsbt_pkg::head_t             head_q;

  vsbt_pkg::head_req_t head_req;
  vsbt_pkg::head_t     head_rd;
  vsbt_pkg::var_req_t  var_req;
  vsbt_pkg::variant_t  var_rd;

  logic                        accept;
  logic                        done_next;
  logic [vsbt_pkg::IDX_W-1:0]  vertex_next;
  vsbt_pkg::status_t           status_next;
  vsbt_pkg::head_t             head_now;
  logic                        do_miss;
  logic                        full;
  logic [vsbt_pkg::IDX_W-1:0]  new_index;
  logic [vsbt_pkg::SLOT_W-1:0] new_slot;

  vsbt_head_mem u_head (
    .clk     (clk),
    .req     (head_req),
    .rd_data (head_rd)
  );

  vsbt_var_mem u_var (
    .clk     (clk),
    .req     (var_req),
    .rd_data (var_rd)
  );

  assign busy   = (state != vsbt_pkg::S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  // register read
  always_comb begin
    prdata = '0;
    if (paddr == vsbt_pkg::ADDR_VERT_TOTAL) begin
      prdata = vsbt_pkg::CFG_DATA_W'(vert_total);
    end
  end

  // head in use: fresh from memory in LOOKUP, held copy during the walk
  assign head_now  = (state == vsbt_pkg::S_LOOKUP) ? head_rd : head_q;
  assign full      = (variants_used == vsbt_pkg::USED_W'(vsbt_pkg::MAX_VARIANTS));
  assign new_slot  = variants_used[vsbt_pkg::SLOT_W-1:0];
  assign new_index = head_now.valid
                   ? vsbt_pkg::IDX_W'(vert_total) + appended_count
                   : vsbt_pkg::IDX_W'(sv);

  // sequencer: head read, list walk, allocation
  always_comb begin
    state_next          = state;
    head_req            = '0;
    var_req             = '0;
    done_next           = 1'b0;
    vertex_next         = '0;
    status_next         = vsbt_pkg::ST_REUSED;
    do_miss             = 1'b0;
    variants_used_next  = variants_used;
    appended_count_next = appended_count;

    case (state)
      vsbt_pkg::S_CLEAR: begin
        head_req.wr_en   = 1'b1;
        head_req.wr_addr = clr_addr;
        if (clr_addr == vsbt_pkg::VERT_W'(vsbt_pkg::MAX_VERTS - 1)) begin
          state_next = vsbt_pkg::S_IDLE;
        end
      end
      vsbt_pkg::S_IDLE: begin
        if (start) begin
          if ({1'b0, src_vert} >= vert_total) begin
            done_next   = 1'b1;
            status_next = vsbt_pkg::ST_RANGE;
          end else begin
            head_req.rd_en   = 1'b1;
            head_req.rd_addr = src_vert;
            state_next       = vsbt_pkg::S_LOOKUP;
          end
        end
      end
      vsbt_pkg::S_LOOKUP: begin
        if (head_rd.valid &&
            (vsbt_pkg::USED_W'(head_rd.slot) < variants_used)) begin
          var_req.rd_en   = 1'b1;
          var_req.rd_addr = head_rd.slot;
          state_next      = vsbt_pkg::S_WALK;
        end else begin
          do_miss = 1'b1;
        end
      end
      vsbt_pkg::S_WALK: begin
        if (vsbt_pkg::frame_eq(var_rd, tx, ty, tz, tw)) begin
          done_next   = 1'b1;
          vertex_next = var_rd.target;
          status_next = vsbt_pkg::ST_REUSED;
          state_next  = vsbt_pkg::S_IDLE;
        end else if (var_rd.link_ok &&
                     (vsbt_pkg::USED_W'(var_rd.link) < variants_used)) begin
          var_req.rd_en   = 1'b1;
          var_req.rd_addr = var_rd.link;
        end else begin
          do_miss = 1'b1;
        end
      end
      default: begin
        state_next = vsbt_pkg::S_IDLE;
      end
    endcase

    // miss: unless the store is full, allocate the next variant and link it at the list head
    if (do_miss) begin
      done_next  = 1'b1;
      state_next = vsbt_pkg::S_IDLE;
      if (full) begin
        status_next = vsbt_pkg::ST_FULL;
      end else begin
        var_req.wr_en                      = 1'b1;
        var_req.wr_addr                    = new_slot;
        var_req.wr_data.frame_xy           = {ty, tx};
        var_req.wr_data.frame_zw           = {tw, tz};
        var_req.wr_data.target             = new_index;
        var_req.wr_data.link_ok            = head_now.valid;
        var_req.wr_data.link               = head_now.valid ? head_now.slot : '0;
        head_req.wr_en                     = 1'b1;
        head_req.wr_addr                   = sv;
        head_req.wr_data.valid             = 1'b1;
        head_req.wr_data.slot              = new_slot;
        variants_used_next                 = variants_used + 1'b1;
        vertex_next                        = new_index;
        if (head_now.valid) begin
          status_next         = vsbt_pkg::ST_NEW_APPEND;
          appended_count_next = appended_count + 1'b1;
        end else begin
          status_next = vsbt_pkg::ST_NEW_SRC;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= vsbt_pkg::S_CLEAR;
      clr_addr       <= '0;
      vert_total     <= vsbt_pkg::VC_RESET;
      variants_used  <= '0;
      appended_count <= '0;
      done           <= 1'b0;
    end else begin
      state          <= state_next;
      variants_used  <= variants_used_next;
      appended_count <= appended_count_next;
      done           <= done_next;
      if (state == vsbt_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (psel && penable && pwrite && pready &&
          (paddr == vsbt_pkg::ADDR_VERT_TOTAL)) begin
        vert_total <= pwdata[vsbt_pkg::VC_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sv <= src_vert;
      tx <= tangent_x;
      ty <= tangent_y;
      tz <= tangent_z;
      tw <= handed_sign;
    end
    if (state == vsbt_pkg::S_LOOKUP) begin
      head_q <= head_rd;
    end
    if (done_next) begin
      dst_vert <= vertex_next;
      status   <= status_next;
    end
  end

endmodule

[rtl/vsbt_head_mem.sv]
// List head memory: one entry per source vertex, registered read
module vsbt_head_mem (
  input  logic               clk,
  input  vsbt_pkg::head_req_t req,
  output vsbt_pkg::head_t     rd_data
);

  vsbt_pkg::head_t mem [vsbt_pkg::MAX_VERTS];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/vsbt_var_mem.sv]
// Variant store: frame, output vertex and list link per variant, registered read
module vsbt_var_mem (
  input  logic               clk,
  input  vsbt_pkg::var_req_t req,
  output vsbt_pkg::variant_t rd_data
);

  vsbt_pkg::variant_t mem [vsbt_pkg::MAX_VARIANTS];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/vsbt_checker.sv]
// Port-level checker for the vertex split block, bound to the top level
`include "vertex_split_by_tangent_top_assert.svh"

module vsbt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [vsbt_pkg::IDX_W-1:0]  dst_vert,
  input logic [2:0]                  status
);

  logic rejected;
  logic src_new;
  logic src_in_range;

  assign rejected     = done && (status == vsbt_pkg::ST_RANGE || status == vsbt_pkg::ST_FULL);
  assign src_new      = done && (status == vsbt_pkg::ST_NEW_SRC);
  assign src_in_range = dst_vert < vsbt_pkg::IDX_W'(vsbt_pkg::MAX_VERTS);

  // rejected corners carry index zero
  `VSBT_ASSERT_NOW(a_reject_zero, rejected, dst_vert == '0, "rejected corner with nonzero index")

  // a first variant's index lies inside the vertex range
  `VSBT_ASSERT_NOW(a_src_range, src_new, src_in_range, "source-slot index out of vertex range")

  // an accepted word either finishes next cycle or keeps the block busy
  `VSBT_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted word dropped")

  // no result without a word in flight
  `VSBT_ASSERT_NOW(a_no_phantom, done, $past(start || busy), "result without accepted word")

endmodule

bind vertex_split_by_tangent_top vsbt_checker u_vsbt_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .dst_vert (dst_vert),
  .status   (status)
);

[verif/tb_top.sv]
// Self-checking testbench for vertex_split_by_tangent_top: corner stream and register port
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int REPORT_MAX  = 10;

  // float bit patterns used by the directed corners
  localparam logic [vsbt_pkg::WORD_W-1:0] POS_ZERO   = 32'h0000_0000;
  localparam logic [vsbt_pkg::WORD_W-1:0] NEG_ZERO   = 32'h8000_0000;
  localparam logic [vsbt_pkg::WORD_W-1:0] PLUS_ONE   = 32'h3F80_0000;
  localparam logic [vsbt_pkg::WORD_W-1:0] MINUS_ONE  = 32'hBF80_0000;
  localparam logic [vsbt_pkg::WORD_W-1:0] POS_INF    = 32'h7F80_0000;
  localparam logic [vsbt_pkg::WORD_W-1:0] NEG_INF    = 32'hFF80_0000;
  localparam logic [vsbt_pkg::WORD_W-1:0] QUIET_NAN  = 32'h7FC0_0000;
  localparam logic [vsbt_pkg::WORD_W-1:0] SIG_NAN    = 32'h7F80_0001;
  localparam logic [vsbt_pkg::WORD_W-1:0] MAX_NAN    = 32'h7FFF_FFFF;
  localparam logic [vsbt_pkg::WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [vsbt_pkg::WORD_W-1:0] POS_DENORM = 32'h0000_0001;
  localparam logic [vsbt_pkg::WORD_W-1:0] NEG_DENORM = 32'h8000_0001;

  typedef struct packed {
    logic [vsbt_pkg::WORD_W-1:0] x;
    logic [vsbt_pkg::WORD_W-1:0] y;
    logic [vsbt_pkg::WORD_W-1:0] z;
    logic [vsbt_pkg::WORD_W-1:0] w;
  } tangent_frame_t;

  typedef struct {
    logic [vsbt_pkg::IDX_W-1:0] vertex;
    vsbt_pkg::status_t          code;
  } corner_result_t;

  // Split predictor plus the queue of results still owed by the block
  class vertex_split_sb;
    logic [vsbt_pkg::VC_W-1:0]   vert_total;
    bit                          head_valid[vsbt_pkg::MAX_VERTS];
    logic [vsbt_pkg::SLOT_W-1:0] head_slot[vsbt_pkg::MAX_VERTS];
    tangent_frame_t              stored_frame[vsbt_pkg::MAX_VARIANTS];
    logic [vsbt_pkg::IDX_W-1:0]  target[vsbt_pkg::MAX_VARIANTS];
    bit                          link_ok[vsbt_pkg::MAX_VARIANTS];
    logic [vsbt_pkg::SLOT_W-1:0] link[vsbt_pkg::MAX_VARIANTS];
    int unsigned                 variants_used;
    logic [vsbt_pkg::IDX_W-1:0]  appended_count;
    corner_result_t              expected_q[$];
    int                          mismatches;

    function new();
      vert_total     = vsbt_pkg::VC_RESET;
      variants_used  = 0;
      appended_count = '0;
      mismatches     = 0;
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    // +0 and -0 are equal, a NaN matches nothing
    function bit same_float(input logic [vsbt_pkg::WORD_W-1:0] a,
                            input logic [vsbt_pkg::WORD_W-1:0] b);
      if (a[vsbt_pkg::WORD_W-2:0] > 31'h7F80_0000 ||
          b[vsbt_pkg::WORD_W-2:0] > 31'h7F80_0000) return 1'b0;
      return (a == b) || ((a[vsbt_pkg::WORD_W-2:0] | b[vsbt_pkg::WORD_W-2:0]) == '0);
    endfunction

    function bit same_frame(input tangent_frame_t a, input tangent_frame_t b);
      return same_float(a.x, b.x) && same_float(a.y, b.y) &&
             same_float(a.z, b.z) && same_float(a.w, b.w);
    endfunction

    // Accepted corner: walk the vertex's list, then reuse, allocate or refuse
    function void note_corner(input logic [vsbt_pkg::VERT_W-1:0] sv, input tangent_frame_t f);
      corner_result_t r;
      int unsigned    lim;
      int unsigned    slot;
      int unsigned    steps;
      bit             found;
      lim   = (vert_total > vsbt_pkg::MAX_VERTS) ? vsbt_pkg::MAX_VERTS : vert_total;
      found = 1'b0;
      slot  = 0;
      if (sv >= lim) begin
        r.vertex = '0;
        r.code   = vsbt_pkg::ST_RANGE;
      end else begin
        if (head_valid[sv]) begin
          slot = head_slot[sv];
          for (steps = 0; steps <= variants_used; steps++) begin
            if (slot >= variants_used) break;
            if (same_frame(stored_frame[slot], f)) begin
              found = 1'b1;
              break;
            end
            if (!link_ok[slot]) break;
            slot = link[slot];
          end
        end
        if (found) begin
          r.vertex = target[slot];
          r.code   = vsbt_pkg::ST_REUSED;
        end else if (variants_used >= vsbt_pkg::MAX_VARIANTS) begin
          r.vertex = '0;
          r.code   = vsbt_pkg::ST_FULL;
        end else begin
          slot = variants_used;
          if (!head_valid[sv]) begin
            r.vertex      = vsbt_pkg::IDX_W'(sv);
            r.code        = vsbt_pkg::ST_NEW_SRC;
            link_ok[slot] = 1'b0;
            link[slot]    = '0;
          end else begin
            // appended index wraps at the index width
            r.vertex       = vert_total + appended_count;
            appended_count = appended_count + 1'b1;
            r.code         = vsbt_pkg::ST_NEW_APPEND;
            link_ok[slot]  = 1'b1;
            link[slot]     = head_slot[sv];
          end
          stored_frame[slot] = f;
          target[slot]       = r.vertex;
          head_slot[sv]      = vsbt_pkg::SLOT_W'(slot);
          head_valid[sv]     = 1'b1;
          variants_used++;
        end
      end
      expected_q = {expected_q, r};
    endfunction

    function void check_result(input logic [vsbt_pkg::IDX_W-1:0] vtx, input logic [2:0] code);
      corner_result_t e;
      if (expected_q.size() == 0) begin
        flag($sformatf("result vertex %0d status %0d with no corner pending", vtx, code));
        return;
      end
      e = expected_q.pop_front();
      if (vtx !== e.vertex)
        flag($sformatf("dst_vert expected %0d got %0d", e.vertex, vtx));
      if (code !== e.code)
        flag($sformatf("status expected %0d got %0d", e.code, code));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic [vsbt_pkg::VERT_W-1:0]     src_vert = '0;
  logic [vsbt_pkg::WORD_W-1:0]     tangent_x = '0;
  logic [vsbt_pkg::WORD_W-1:0]     tangent_y = '0;
  logic [vsbt_pkg::WORD_W-1:0]     tangent_z = '0;
  logic [vsbt_pkg::WORD_W-1:0]     handed_sign = '0;
  logic                            done;
  logic [vsbt_pkg::IDX_W-1:0]      dst_vert;
  logic [2:0]                      status;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [vsbt_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [vsbt_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [vsbt_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  vertex_split_sb sb;
  tangent_frame_t frame_pool[16];
  int             quiet_cycles = 0;

  vertex_split_by_tangent_top uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result check and stall watchdog
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(dst_vert, status);
    if (done || (start && !busy)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL vertex_split_by_tangent_top");
      $finish;
    end
  end

  function automatic logic [vsbt_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(15))
      0:       return POS_ZERO;
      1:       return NEG_ZERO;
      2:       return POS_INF;
      3:       return NEG_INF;
      4:       return QUIET_NAN;
      5:       return SIG_NAN;
      6:       return ALL_ONES;
      7:       return PLUS_ONE;
      8:       return MINUS_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic tangent_frame_t random_frame();
    tangent_frame_t f;
    f.x = random_word();
    f.y = random_word();
    f.z = random_word();
    f.w = random_word();
    return f;
  endfunction

  // One corner word: optional sender gap, then hold until taken
  task automatic send_corner(input logic [vsbt_pkg::VERT_W-1:0] sv, input tangent_frame_t f,
                             input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start       <= 1'b1;
    src_vert    <= sv;
    tangent_x   <= f.x;
    tangent_y   <= f.y;
    tangent_z   <= f.z;
    handed_sign <= f.w;
    do @(posedge clk); while (busy);
    sb.note_corner(sv, f);
  endtask

  // drop start in the step of the last acceptance
  task automatic end_burst();
    start <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  // Write the vertex total, then read it back
  task automatic program_vert_total(input logic [vsbt_pkg::CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= vsbt_pkg::ADDR_VERT_TOTAL;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.vert_total = value[vsbt_pkg::VC_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== vsbt_pkg::CFG_DATA_W'(sb.vert_total))
      sb.flag($sformatf("vert_total readback expected %0d got %0d", sb.vert_total, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Signed zeros, NaN misses, infinities, deep hits, both ends of the vertex range
  task automatic run_directed();
    send_corner(12'd0, tangent_frame_t'{POS_ZERO, PLUS_ONE, NEG_ZERO, MINUS_ONE}, 0);
    send_corner(12'd0, tangent_frame_t'{POS_ZERO, PLUS_ONE, NEG_ZERO, MINUS_ONE}, 0);
    send_corner(12'd0, tangent_frame_t'{NEG_ZERO, PLUS_ONE, POS_ZERO, MINUS_ONE}, 0);
    send_corner(12'd0, tangent_frame_t'{QUIET_NAN, PLUS_ONE, POS_ZERO, PLUS_ONE}, 0);
    send_corner(12'd0, tangent_frame_t'{QUIET_NAN, PLUS_ONE, POS_ZERO, PLUS_ONE}, 0);
    send_corner(12'd0, tangent_frame_t'{POS_ZERO, PLUS_ONE, NEG_ZERO, MINUS_ONE}, 0);
    send_corner(12'd4095, tangent_frame_t'{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 0);
    send_corner(12'd4095, tangent_frame_t'{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 0);
    send_corner(12'd4095, tangent_frame_t'{POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO}, 0);
    send_corner(12'd4095, tangent_frame_t'{NEG_ZERO, NEG_ZERO, NEG_ZERO, NEG_ZERO}, 0);
    send_corner(12'd1, tangent_frame_t'{POS_INF, PLUS_ONE, POS_ZERO, PLUS_ONE}, 0);
    send_corner(12'd1, tangent_frame_t'{POS_INF, PLUS_ONE, POS_ZERO, PLUS_ONE}, 0);
    send_corner(12'd1, tangent_frame_t'{SIG_NAN, PLUS_ONE, POS_ZERO, PLUS_ONE}, 0);
    send_corner(12'd1, tangent_frame_t'{MAX_NAN, PLUS_ONE, POS_ZERO, PLUS_ONE}, 0);
    send_corner(12'd1, tangent_frame_t'{NEG_INF, PLUS_ONE, POS_ZERO, PLUS_ONE}, 0);
    send_corner(12'd1, tangent_frame_t'{POS_INF, PLUS_ONE, NEG_ZERO, PLUS_ONE}, 0);
    send_corner(12'd2, tangent_frame_t'{POS_DENORM, PLUS_ONE, PLUS_ONE, MINUS_ONE}, 0);
    send_corner(12'd2, tangent_frame_t'{NEG_DENORM, PLUS_ONE, PLUS_ONE, MINUS_ONE}, 0);
    send_corner(12'd2048,
                tangent_frame_t'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 0);
    send_corner(12'd2048,
                tangent_frame_t'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 0);
    end_burst();
  endtask

  // Random corners: mostly a few hot vertices and pooled frames, so lists grow and hit
  task automatic run_phase(input int count, input int idle_pct);
    logic [vsbt_pkg::VERT_W-1:0] hot[8];
    int unsigned                 lim;
    int unsigned                 pick;
    logic [vsbt_pkg::VERT_W-1:0] sv;
    tangent_frame_t              f;
    lim = (sb.vert_total > vsbt_pkg::MAX_VERTS) ? vsbt_pkg::MAX_VERTS : sb.vert_total;
    foreach (hot[i]) begin
      hot[i] = (lim > 0) ? vsbt_pkg::VERT_W'($urandom_range(lim - 1))
                         : vsbt_pkg::VERT_W'($urandom);
    end
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        sv = hot[$urandom_range(7)];
      end else if (pick < 90) begin
        sv = vsbt_pkg::VERT_W'($urandom);
      end else begin
        case ($urandom_range(2))
          0:       sv = (lim > 0) ? vsbt_pkg::VERT_W'(lim - 1) : '0;
          1:       sv = (lim < vsbt_pkg::MAX_VERTS) ? vsbt_pkg::VERT_W'(lim) : '1;
          default: sv = '1;
        endcase
      end
      if ($urandom_range(99) < 70) begin
        f = frame_pool[$urandom_range(15)];
        // same frame with zero signs chosen at random should still hit
        if ($urandom_range(3) == 0) begin
          if (f.x[vsbt_pkg::WORD_W-2:0] == '0) f.x[vsbt_pkg::WORD_W-1] = 1'($urandom_range(1));
          if (f.y[vsbt_pkg::WORD_W-2:0] == '0) f.y[vsbt_pkg::WORD_W-1] = 1'($urandom_range(1));
          if (f.z[vsbt_pkg::WORD_W-2:0] == '0) f.z[vsbt_pkg::WORD_W-1] = 1'($urandom_range(1));
          if (f.w[vsbt_pkg::WORD_W-2:0] == '0) f.w[vsbt_pkg::WORD_W-1] = 1'($urandom_range(1));
        end
      end else begin
        f = random_frame();
      end
      send_corner(sv, f, idle_pct);
    end
    end_burst();
  endtask

  initial begin
    sb = new();
    foreach (frame_pool[i]) frame_pool[i] = random_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // head clearing pass runs with busy high
    wait_idle();
    // reset value again, with junk above the field
    program_vert_total(32'hA5A5_F000);
    run_directed();

    wait_idle();
    program_vert_total(32'd1);
    run_phase(120, 0);
    wait_idle();
    // above the vertex limit: range clamps, appended base does not
    program_vert_total(32'd8191);
    run_phase(140, 73);
    wait_idle();
    program_vert_total(32'd0);
    run_phase(30, 0);
    wait_idle();
    program_vert_total(32'd3);
    run_phase(120, 19);
    wait_idle();
    program_vert_total($urandom_range(4096, 1));
    run_phase(140, 0);
    wait_idle();
    program_vert_total(32'd4096);
    run_phase(120, 73);
    run_phase(40, 19);

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("PASS vertex_split_by_tangent_top");
    else
      $display("FAIL vertex_split_by_tangent_top");
    $finish;
  end

endmodule
